// ===== hw/rtl/qsps_pkg.sv =====
// Package for the query string pair splitter.
// Holds the port item types, the per-item result bundle and the result kinds.
// No dependencies.
package qsps_pkg;

    // Most results one input item can cause
    localparam int unsigned MAX_RES = 4;
    localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);
    localparam int unsigned IDX_W   = $clog2(MAX_RES);

    // Result kinds
    typedef enum logic [2:0] {
        KIND_KEY_BYTE = 3'd0,
        KIND_KEY_END  = 3'd1,
        KIND_VAL_BYTE = 3'd2,
        KIND_VAL_END  = 3'd3,
        KIND_DROP     = 3'd4
    } t_kind;

    // Character codes
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
        logic       run_end;
        logic       query_end;
    } t_out_item;

    // One result slot inside a bundle
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } t_slot;

    // All results caused by one input item
    typedef struct packed {
        logic [CNT_W-1:0]      cnt;
        logic                  fin;
        t_slot [MAX_RES-1:0]   slot;
    } t_bundle;

    // Append one result; extra results beyond the limit are discarded
    function automatic t_bundle bundle_push(t_bundle bun, t_kind kind, logic [7:0] data);
        t_bundle res;
        res = bun;
        if (bun.cnt < CNT_W'(MAX_RES)) begin
            res.slot[bun.cnt[IDX_W-1:0]].kind = kind;
            res.slot[bun.cnt[IDX_W-1:0]].data = data;
            res.cnt = bun.cnt + CNT_W'(1);
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/qsps_front.sv =====
// Front end of the query string pair splitter: accepts input items, keeps the
// key/value/escape state and builds the bundle of results for each item.
// Depends on qsps_pkg.
module qsps_front import qsps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    input  logic     i_q_full,
    output logic     o_push,
    output t_bundle  o_bundle
);

    logic       r_in_value, n_in_value;
    logic       r_key_has,  n_key_has;
    logic [1:0] r_esc,      n_esc;
    logic [7:0] r_held,     n_held;
    logic       r_sil,      n_sil;
    logic       acc;
    logic [7:0] b;
    logic       fin;
    t_bundle    bun;

    function automatic logic is_hex(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'd87);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'd55);
        end
        return v;
    endfunction

    // Value byte: a zero silences the rest of the value
    function automatic void put_value(inout t_bundle bu, inout logic sil, input logic [7:0] v);
        if (!sil) begin
            if (v == 8'h00) begin
                sil = 1'b1;
            end else begin
                bu = bundle_push(bu, KIND_VAL_BYTE, v);
            end
        end
    endfunction

    // Emit a held '%' and digit literally
    function automatic void flush_escape(inout t_bundle bu, inout logic sil,
                                         inout logic [1:0] esc, inout logic [7:0] hd);
        if (esc == 2'd1 || esc == 2'd2) begin
            put_value(bu, sil, CH_PERCENT);
        end
        if (esc == 2'd2) begin
            put_value(bu, sil, hd);
        end
        esc = 2'd0;
        hd  = 8'h00;
    endfunction

    function automatic void fresh_byte(inout t_bundle bu, inout logic sil,
                                       inout logic [1:0] esc, input logic [7:0] c);
        if (c == CH_PERCENT) begin
            esc = 2'd1;
        end else begin
            put_value(bu, sil, c);
        end
    endfunction

    assign o_in_ready = !i_q_full;
    assign acc        = i_in_valid && o_in_ready;
    assign b          = (i_in_item.data_byte == CH_PLUS) ? CH_SPACE : i_in_item.data_byte;
    assign fin        = i_in_item.final_byte;

    // Result bundle and next state for the offered item
    always_comb begin
        bun        = '0;
        n_in_value = r_in_value;
        n_key_has  = r_key_has;
        n_esc      = r_esc;
        n_held     = r_held;
        n_sil      = r_sil;
        if (!n_in_value) begin
            if (b == CH_EQUALS) begin
                bun        = bundle_push(bun, KIND_KEY_END, 8'h00);
                n_in_value = 1'b1;
                n_key_has  = 1'b0;
                n_esc      = 2'd0;
                n_held     = 8'h00;
                n_sil      = 1'b0;
            end else begin
                bun       = bundle_push(bun, KIND_KEY_BYTE, b);
                n_key_has = 1'b1;
            end
        end else if (b == CH_AMP) begin
            flush_escape(bun, n_sil, n_esc, n_held);
            bun        = bundle_push(bun, KIND_VAL_END, 8'h00);
            n_in_value = 1'b0;
            n_key_has  = 1'b0;
            n_sil      = 1'b0;
        end else if (n_sil) begin
            n_esc = 2'd0;
        end else if (n_esc == 2'd1) begin
            if (is_hex(b)) begin
                n_held = b;
                n_esc  = 2'd2;
            end else begin
                flush_escape(bun, n_sil, n_esc, n_held);
                fresh_byte(bun, n_sil, n_esc, b);
            end
        end else if (n_esc == 2'd2) begin
            if (is_hex(b)) begin
                n_esc  = 2'd0;
                put_value(bun, n_sil, {hex_val(n_held), hex_val(b)});
                n_held = 8'h00;
            end else begin
                flush_escape(bun, n_sil, n_esc, n_held);
                fresh_byte(bun, n_sil, n_esc, b);
            end
        end else begin
            n_esc = 2'd0;
            fresh_byte(bun, n_sil, n_esc, b);
        end

        // End of query: close the open run, then start afresh
        if (fin) begin
            if (n_in_value) begin
                flush_escape(bun, n_sil, n_esc, n_held);
                bun = bundle_push(bun, KIND_VAL_END, 8'h00);
            end else if (n_key_has) begin
                bun = bundle_push(bun, KIND_DROP, 8'h00);
            end
            n_in_value = 1'b0;
            n_key_has  = 1'b0;
            n_esc      = 2'd0;
            n_held     = 8'h00;
            n_sil      = 1'b0;
        end
        bun.fin = fin;
    end

    assign o_push   = acc && (bun.cnt != '0);
    assign o_bundle = bun;

    // Scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_value <= 1'b0;
            r_key_has  <= 1'b0;
            r_esc      <= 2'd0;
            r_held     <= 8'h00;
            r_sil      <= 1'b0;
        end else if (acc) begin
            r_in_value <= n_in_value;
            r_key_has  <= n_key_has;
            r_esc      <= n_esc;
            r_held     <= n_held;
            r_sil      <= n_sil;
        end
    end

`ifndef SYNTHESIS
    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && fin |=> !r_in_value && !r_key_has && r_esc == 2'd0 && !r_sil)
        else $error("state not cleared after final byte");
    a_esc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc != 2'd3)
        else $error("escape count out of range");
    a_key_no_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_value |-> r_esc == 2'd0 && !r_sil)
        else $error("escape or silence pending while scanning a key");
`endif

endmodule

// ===== hw/rtl/qsps_queue.sv =====
// Short bundle queue between front and back of the query string pair splitter.
// Depends on qsps_pkg.
module qsps_queue import qsps_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_valid,
    output t_bundle o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_Q = $clog2(DEPTH + 1);

    t_bundle            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_Q-1:0]   r_cnt;

    assign o_full  = (r_cnt == CNT_Q'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign n_wr    = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
    assign n_rd    = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_Q'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_Q'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_Q'(DEPTH))
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
`endif

endmodule

// ===== hw/rtl/qsps_back.sv =====
// Back end of the query string pair splitter: walks the head bundle, one result
// per cycle unless the output stalls, into the output register. Depends on qsps_pkg.
module qsps_back import qsps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_bundle   i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    t_out_item        r_out;
    logic             adv;
    logic             last;

    assign adv  = i_head_valid && (!r_out_valid || i_out_ready);
    assign last = ({1'b0, r_idx} == (i_head.cnt - CNT_W'(1)));
    assign o_pop = adv && last;

    // Slot index within the head bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (adv) begin
            r_idx <= last ? '0 : r_idx + IDX_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.kind      <= i_head.slot[r_idx].kind;
            r_out.out_byte  <= i_head.slot[r_idx].data;
            r_out.run_end   <= last;
            r_out.query_end <= last && i_head.fin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> {1'b0, r_idx} < i_head.cnt)
        else $error("slot index past bundle end");
    a_mid_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != '0 |-> i_head_valid)
        else $error("bundle left part-way with queue empty");
    a_qend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.query_end |-> r_out.run_end)
        else $error("query end on a result that does not end its run");
`endif

endmodule

// ===== hw/rtl/query_string_pair_splitter.sv =====
// Query string pair splitter with percent decoding (top level).
// Instantiates qsps_front, qsps_queue and qsps_back; depends on qsps_pkg.
//
// Input channel (i_in_valid / o_in_ready / i_in_item): one query string byte
// per item, with final_byte marking the last byte of the string. Output
// channel (o_out_valid / i_out_ready / o_out_item): key bytes, key end, value
// bytes, value end and a drop marker for a key left without '='.
// run_end flags the last result of an input byte, query_end the last of a
// string.
// An input byte causes zero to four results. The front end takes one byte
// per cycle while the queue is not full and writes its results as one bundle
// into a QUEUE_DEPTH entry queue; the back end sends one result per cycle,
// while the receiver is ready, from the queue head through an output register.
// A byte's results are registered first in the queue and then in the output
// register. Sustained rate is one byte per cycle while bytes cause at most one
// result each and the receiver is ready; otherwise the single-result-per-cycle
// output port sets the rate and the queue absorbs bursts. When the receiver stalls
// the queue fills and o_in_ready drops once it is full. Synchronous reset clears
// the scan state, the queue and the output valid flag; no clearing pass is needed.
module query_string_pair_splitter import qsps_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic    q_full;
    logic    q_push;
    logic    q_pop;
    logic    q_valid;
    t_bundle q_in;
    t_bundle q_head;

    // Accept and classify
    qsps_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_bundle   (q_in)
    );

    // Decoupling queue
    qsps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_bundle (q_in),
        .o_full   (q_full),
        .i_pop    (q_pop),
        .o_valid  (q_valid),
        .o_head   (q_head)
    );

    // Result serialiser
    qsps_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule

// ===== sim/tb_query_string_pair_splitter.sv =====
// Self-checking testbench for query_string_pair_splitter: drives query string bytes,
// predicts key/value/drop results and checks every result field by field.
// Depends on qsps_pkg and the query_string_pair_splitter RTL.
module tb_query_string_pair_splitter;
    import qsps_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 290;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned QUIET_LIMIT   = 1000;

    // Escape decoder stages
    localparam logic [1:0] ESC_NONE    = 2'd0;
    localparam logic [1:0] ESC_PERCENT = 2'd1;
    localparam logic [1:0] ESC_DIGIT   = 2'd2;

    // Receiver back-pressure patterns
    typedef enum logic [1:0] {RX_FREE, RX_MOSTLY, RX_COIN, RX_CHOKE} t_rx_mode;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    query_string_pair_splitter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // Scan state mirrored by the predictor
    logic        scan_in_value;
    logic        key_nonempty;
    logic [1:0]  escape_stage;
    logic [7:0]  held_digit;
    logic        value_muted;
    int unsigned results_this_byte;

    t_out_item   expected_q[$];
    logic [7:0]  query_buf[$];
    int unsigned error_count  = 0;
    int unsigned bytes_sent   = 0;
    int unsigned burst_left   = 0;
    int unsigned quiet_cycles = 0;

    string hex_digits = "0123456789abcdefABCDEF";
    string non_hex    = "gGzZ=+%.~ _";

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic bit is_hex_char(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_nibble(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 4'(c - "0");
        if (c >= "a" && c <= "f")
            return 4'(c - "a" + 8'd10);
        if (c >= "A" && c <= "F")
            return 4'(c - "A" + 8'd10);
        return 4'd0;
    endfunction

    function automatic void clear_scan_state();
        scan_in_value = 1'b0;
        key_nonempty  = 1'b0;
        escape_stage  = ESC_NONE;
        held_digit    = 8'd0;
        value_muted   = 1'b0;
    endfunction

    // At most MAX_RES results per byte; anything beyond is lost
    function automatic void push_result(t_kind k, logic [7:0] b);
        t_out_item r;
        if (results_this_byte < MAX_RES) begin
            r.kind      = k;
            r.out_byte  = b;
            r.run_end   = 1'b0;
            r.query_end = 1'b0;
            expected_q.push_back(r);
            results_this_byte++;
        end
    endfunction

    // A zero byte in a value mutes the rest of it
    function automatic void put_value(logic [7:0] b);
        if (value_muted)
            return;
        if (b == 8'd0)
            value_muted = 1'b1;
        else
            push_result(KIND_VAL_BYTE, b);
    endfunction

    // Held '%' and digit go out literally
    function automatic void flush_escape();
        if (escape_stage == ESC_PERCENT || escape_stage == ESC_DIGIT)
            put_value(CH_PERCENT);
        if (escape_stage == ESC_DIGIT)
            put_value(held_digit);
        escape_stage = ESC_NONE;
        held_digit   = 8'd0;
    endfunction

    function automatic void start_value_char(logic [7:0] c);
        if (c == CH_PERCENT)
            escape_stage = ESC_PERCENT;
        else
            put_value(c);
    endfunction

    function automatic void predict_byte(logic [7:0] raw, logic last);
        logic [7:0]  c;
        int unsigned tail;
        results_this_byte = 0;
        c = (raw == CH_PLUS) ? CH_SPACE : raw;

        if (!scan_in_value) begin
            if (c == CH_EQUALS) begin
                push_result(KIND_KEY_END, 8'd0);
                scan_in_value = 1'b1;
                key_nonempty  = 1'b0;
                escape_stage  = ESC_NONE;
                held_digit    = 8'd0;
                value_muted   = 1'b0;
            end else begin
                push_result(KIND_KEY_BYTE, c);
                key_nonempty = 1'b1;
            end
        end else if (c == CH_AMP) begin
            flush_escape();
            push_result(KIND_VAL_END, 8'd0);
            scan_in_value = 1'b0;
            key_nonempty  = 1'b0;
            value_muted   = 1'b0;
        end else if (value_muted) begin
            escape_stage = ESC_NONE;
        end else if (escape_stage == ESC_PERCENT) begin
            if (is_hex_char(c)) begin
                held_digit   = c;
                escape_stage = ESC_DIGIT;
            end else begin
                flush_escape();
                start_value_char(c);
            end
        end else if (escape_stage == ESC_DIGIT) begin
            if (is_hex_char(c)) begin
                escape_stage = ESC_NONE;
                put_value({hex_nibble(held_digit), hex_nibble(c)});
                held_digit = 8'd0;
            end else begin
                flush_escape();
                start_value_char(c);
            end
        end else begin
            escape_stage = ESC_NONE;
            start_value_char(c);
        end

        // End of the query string: close the value or drop the open key
        if (last) begin
            if (scan_in_value) begin
                flush_escape();
                push_result(KIND_VAL_END, 8'd0);
            end else if (key_nonempty) begin
                push_result(KIND_DROP, 8'd0);
            end
            clear_scan_state();
        end

        if (results_this_byte > 0) begin
            tail = expected_q.size() - 1;
            expected_q[tail].run_end   = 1'b1;
            expected_q[tail].query_end = last;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                          o_out_item.kind, o_out_item.out_byte));
            end else begin
                want = expected_q.pop_front();
                if (o_out_item.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d",
                                              o_out_item.kind, want.kind));
                if (o_out_item.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              o_out_item.out_byte, want.out_byte));
                if (o_out_item.run_end !== want.run_end)
                    report_mismatch($sformatf("run_end %b, expected %b",
                                              o_out_item.run_end, want.run_end));
                if (o_out_item.query_end !== want.query_end)
                    report_mismatch($sformatf("query_end %b, expected %b",
                                              o_out_item.query_end, want.query_end));
            end
        end
    end

    // Count cycles in which neither channel moves an item
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver stalls: the ready pattern is picked anew at random
    // ------------------------------------------------------------------
    t_rx_mode    rx_mode       = RX_FREE;
    int unsigned rx_phase_left = 0;
    int unsigned rx_tick       = 0;

    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_phase_left == 0) begin
            rx_mode       <= t_rx_mode'($urandom_range(0, 3));
            rx_phase_left <= $urandom_range(16, 96);
        end else begin
            rx_phase_left <= rx_phase_left - 1;
        end
        case (rx_mode)
            RX_FREE:   i_out_ready <= 1'b1;
            RX_MOSTLY: i_out_ready <= ($urandom_range(0, 3) != 0);
            RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
            default:   i_out_ready <= ((rx_tick % 8) < 2);
        endcase
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // One item; bursts of random length with random gaps in between
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= '{data_byte: b, final_byte: is_last};
        do
            @(posedge i_clk);
        while (!o_in_ready);
        predict_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input bit ends_query);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], ends_query && (i == s.len() - 1));
    endtask

    // Sends the built query, final flag on its last byte
    task automatic send_query_buf();
        logic [7:0] c;
        while (query_buf.size() != 0) begin
            c = query_buf.pop_front();
            send_byte(c, query_buf.size() == 0);
        end
    endtask

    // Hold off until every expected result has been taken
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Random query generation
    // ------------------------------------------------------------------
    function automatic logic [7:0] random_key_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0: c = CH_PLUS;
            1: c = CH_AMP;
            2: c = CH_PERCENT;
            3: begin
                c = 8'($urandom_range(1, 255));
                if (c == CH_EQUALS)
                    c = CH_PLUS;
            end
            default: c = 8'("a" + $urandom_range(0, 25));
        endcase
        return c;
    endfunction

    function automatic logic [7:0] random_hex();
        return hex_digits[$urandom_range(0, hex_digits.len() - 1)];
    endfunction

    function automatic logic [7:0] random_non_hex();
        return non_hex[$urandom_range(0, non_hex.len() - 1)];
    endfunction

    // Plain characters, good and broken escapes, and the odd muting zero
    task automatic add_value_token();
        logic [7:0] c;
        case ($urandom_range(0, 11))
            0, 1, 2: query_buf.push_back(8'("a" + $urandom_range(0, 25)));
            3: query_buf.push_back(CH_PLUS);
            4, 5: begin
                query_buf.push_back(CH_PERCENT);
                query_buf.push_back(random_hex());
                query_buf.push_back(random_hex());
            end
            6: begin
                query_buf.push_back(CH_PERCENT);
                query_buf.push_back(random_non_hex());
            end
            7: begin
                query_buf.push_back(CH_PERCENT);
                query_buf.push_back(random_hex());
                query_buf.push_back(random_non_hex());
            end
            8: query_buf.push_back(CH_PERCENT);
            9: begin
                query_buf.push_back(CH_PERCENT);
                query_buf.push_back(random_hex());
            end
            10: begin
                c = 8'($urandom_range(1, 255));
                query_buf.push_back((c == CH_AMP) ? CH_EQUALS : c);
            end
            default: begin
                if ($urandom_range(0, 3) == 0) begin
                    query_buf.push_back(CH_PERCENT);
                    query_buf.push_back("0");
                    query_buf.push_back("0");
                end else begin
                    query_buf.push_back(8'("0" + $urandom_range(0, 9)));
                end
            end
        endcase
    endtask

    task automatic build_random_query();
        int unsigned n_pairs;
        int unsigned tail_kind;
        n_pairs = $urandom_range(1, 4);
        for (int p = 0; p < n_pairs; p++) begin
            if (p != 0)
                query_buf.push_back(CH_AMP);
            repeat ($urandom_range(0, 5)) query_buf.push_back(random_key_char());
            query_buf.push_back(CH_EQUALS);
            repeat ($urandom_range(0, 5)) add_value_token();
        end
        tail_kind = $urandom_range(0, 7);
        if (tail_kind == 0) begin
            // empty key left after the separator
            query_buf.push_back(CH_AMP);
        end else if (tail_kind == 1) begin
            // key with no '=' before the end
            query_buf.push_back(CH_AMP);
            repeat ($urandom_range(1, 4)) query_buf.push_back(random_key_char());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Key bytes at the range limits, '&' and '+' inside a key
    task automatic test_key_bytes();
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_AMP, 1'b0);
        send_byte(CH_PLUS, 1'b0);
        send_byte(CH_EQUALS, 1'b0);
    endtask

    // Broken first digit, broken second digit, then a good escape
    task automatic test_escapes();
        send_text("%z%4%41&", 1'b0);
    endtask

    // Empty value, and an escape cut off by '&'
    task automatic test_empty_and_cut_escape();
        send_text("=&=%4&", 1'b0);
    endtask

    // Escape cut off by the final byte: four results from one item
    task automatic test_result_burst();
        send_text("=%4%", 1'b1);
    endtask

    // Decoded zero mutes the value; value end still comes
    task automatic test_muted_value();
        send_text("=%00+", 1'b1);
    endtask

    // Key without '=' at the end of the query is dropped
    task automatic test_unfinished_key();
        send_text("ab", 1'b1);
    endtask

    task automatic test_random_traffic();
        int unsigned start_count;
        int unsigned pick;
        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 16) begin
                build_random_query();
                send_query_buf();
            end else if (pick < 19) begin
                // unstructured bytes, occasionally ending a query
                repeat ($urandom_range(1, 8))
                    send_byte(8'($urandom_range(1, 255)), $urandom_range(0, 11) == 0);
            end else begin
                wait_for_results();
            end
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        clear_scan_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_key_bytes();
        test_escapes();
        test_empty_and_cut_escape();
        wait_for_results();
        test_result_burst();
        test_muted_value();
        test_unfinished_key();
        wait_for_results();
        test_random_traffic();
        wait_for_results();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/qsps_pkg.sv
hw/rtl/qsps_front.sv
hw/rtl/qsps_queue.sv
hw/rtl/qsps_back.sv
hw/rtl/query_string_pair_splitter.sv
sim/tb_query_string_pair_splitter.sv
